/* hdl/mosa_pkg.sv */
package mosa_pkg;

   localparam int ENTRIES   = 256;
   localparam int LANES     = 16;
   localparam int ROWS      = ENTRIES / LANES;
   localparam int SLOT_BITS = $clog2(ENTRIES);
   localparam int LANE_BITS = $clog2(LANES);
   localparam int ROW_BITS  = $clog2(ROWS);
   localparam int CNT_BITS  = SLOT_BITS + 1;
   localparam int POS_BITS  = SLOT_BITS + 3;

   typedef logic signed [POS_BITS-1:0] pos_type;

   localparam pos_type MID = pos_type'(ENTRIES / 2);

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_OUTSIDE = 2'd2,
      ST_IS_FREE = 2'd3
   } status_type;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   function automatic logic [LANE_BITS-1:0] lowest_set(input logic [LANES-1:0] v);
      logic [LANE_BITS-1:0] r;
      r = '0;
      for (int j = LANES - 1; j >= 0; j--) begin
         if (v[j]) r = LANE_BITS'(j);
      end
      return r;
   endfunction

   function automatic logic [LANE_BITS-1:0] highest_set(input logic [LANES-1:0] v);
      logic [LANE_BITS-1:0] r;
      r = '0;
      for (int j = 0; j < LANES; j++) begin
         if (v[j]) r = LANE_BITS'(j);
      end
      return r;
   endfunction

endpackage

/* hdl/mosa_ram.sv */
module mosa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/middle_out_slot_allocator_unit.sv */
// Middle-out slot allocator.
// req channel: tuser = kind (0 allocate, 1 free), tdata = absolute slot index.
// rsp channel: one transfer per request; tuser = status, tdata carries the
// slot index, the used count and both exclusive window edges.
// csr port: csr_wr_en writes base_index. The user must write it only while no
// request is in flight; the block does not enforce this. Occupancy sits in a
// 16 x 16-bit RAM, one row per read-modify-write step. Each row visit takes a
// read-issue state and then an evaluate state. A full table or a free outside
// the window goes straight to the result; edge extension visits one row; hole
// search scans rows upward from the low edge; a free visits its own row, then
// may shrink the low edge and the high edge by row scans.
// One request is in flight at a time; req_tready is high only when idle.
// A finished result waits in the rsp register; the next request is accepted
// meanwhile, and its result is held back until rsp is taken.
// Reset empties the table at once (row valid bits), centers the window at
// the middle slot and clears base_index. No clearing pass is needed.
module middle_out_slot_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] index
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] slot_index, [40:32] used_count, [49:41] window_low,
   // [58:50] window_high, [63:59] zero
   output logic [63:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import mosa_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_RD   = 4'b0010,
      S_EV   = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   typedef enum logic [2:0] {
      OP_HOLE,
      OP_SET,
      OP_FREE,
      OP_SLO,
      OP_SHI
   } op_type;

   state_type                 state_ff, state_in;
   op_type                    op_ff, op_in;
   logic [ROW_BITS-1:0]       row_ff, row_in;
   logic [SLOT_BITS-1:0]      pick_ff, pick_in;
   logic signed [CNT_BITS-1:0] low_ff, low_in;
   logic [CNT_BITS-1:0]       high_ff, high_in;
   logic [CNT_BITS-1:0]       count_ff, count_in;
   logic [31:0]               base_ff;
   status_type                status_ff, status_in;
   logic [31:0]               idx_ff, idx_in;
   logic [ROWS-1:0]           row_valid_ff;

   logic                      rsp_tvalid_ff;
   logic [63:0]               rsp_tdata_ff;
   logic [1:0]                rsp_tuser_ff;
   logic                      rsp_load;

   logic                      ram_wr_en;
   logic [LANES-1:0]          ram_wr_data;
   logic [LANES-1:0]          ram_rd_data;
   logic [LANES-1:0]          row_data;

   mosa_ram #(.WIDTH(LANES), .DEPTH(ROWS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (row_ff),
      .wr_data (ram_wr_data),
      .rd_en   (state_ff == S_RD),
      .rd_addr (row_ff),
      .rd_data (ram_rd_data)
   );

   // rows never written since reset read as all free
   assign row_data = row_valid_ff[row_ff] ? ram_rd_data : '0;

   assign rsp_load = (state_ff == S_DONE) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      pos_type              lo, hi, lo1, hm1, cnt, rowbase, rowend, pj, f, nl;
      logic [LANES-1:0]     hole_m, slo_m, shi_m, t, lane_bit;
      logic [31:0]          off;
      logic                 in_window, to_high, go_shi;

      state_in    = state_ff;
      op_in       = op_ff;
      row_in      = row_ff;
      pick_in     = pick_ff;
      low_in      = low_ff;
      high_in     = high_ff;
      count_in    = count_ff;
      status_in   = status_ff;
      idx_in      = idx_ff;
      ram_wr_en   = 1'b0;
      ram_wr_data = row_data;
      go_shi      = 1'b0;

      lo      = pos_type'(low_ff);
      hi      = pos_type'(high_ff);
      cnt     = pos_type'(count_ff);
      lo1     = lo + pos_type'(1);
      hm1     = hi - pos_type'(1);
      nl      = lo;
      rowbase = pos_type'({row_ff, {LANE_BITS{1'b0}}});
      rowend  = rowbase + pos_type'(LANES - 1);
      for (int j = 0; j < LANES; j++) begin
         pj        = rowbase + pos_type'(j);
         hole_m[j] = (pj > lo) && (pj < hi);
         slo_m[j]  = (pj >= lo1);
         shi_m[j]  = (pj >= lo1) && (pj <= hm1);
      end
      lane_bit = LANES'(1) << pick_ff[LANE_BITS-1:0];
      t        = '0;
      f        = '0;
      to_high  = 1'b0;

      off       = req_tdata - base_ff;
      in_window = (off < {{(32-CNT_BITS){1'b0}}, high_ff}) &&
                  (low_ff[CNT_BITS-1] || (off > {{(32-CNT_BITS){1'b0}}, low_ff}));

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               status_in = ST_OK;
               if (req_tuser == KIND_ALLOC) begin
                  if (count_ff >= CNT_BITS'(ENTRIES)) begin
                     status_in = ST_FULL;
                     idx_in    = '0;
                     state_in  = S_DONE;
                  end else if (hi - lo - pos_type'(1) > cnt) begin
                     op_in    = OP_HOLE;
                     row_in   = lo1[SLOT_BITS-1:LANE_BITS];
                     state_in = S_RD;
                  end else begin
                     to_high = (MID - lo) > (hm1 - MID);
                     if (to_high && hi >= pos_type'(ENTRIES)) to_high = 1'b0;
                     if (!to_high && lo < pos_type'(0)) to_high = 1'b1;
                     if (to_high) begin
                        pick_in = hi[SLOT_BITS-1:0];
                        high_in = high_ff + CNT_BITS'(1);
                        row_in  = hi[SLOT_BITS-1:LANE_BITS];
                     end else begin
                        pick_in = lo[SLOT_BITS-1:0];
                        low_in  = low_ff - CNT_BITS'(1);
                        row_in  = lo[SLOT_BITS-1:LANE_BITS];
                     end
                     op_in    = OP_SET;
                     state_in = S_RD;
                  end
               end else begin
                  idx_in = req_tdata;
                  if (!in_window) begin
                     status_in = ST_OUTSIDE;
                     state_in  = S_DONE;
                  end else begin
                     pick_in  = off[SLOT_BITS-1:0];
                     row_in   = off[SLOT_BITS-1:LANE_BITS];
                     op_in    = OP_FREE;
                     state_in = S_RD;
                  end
               end
            end
         end
         S_RD: begin
            state_in = S_EV;
         end
         S_EV: begin
            case (op_ff)
               OP_HOLE: begin
                  t = ~row_data & hole_m;
                  if (|t) begin
                     f           = rowbase + pos_type'(lowest_set(t));
                     ram_wr_en   = 1'b1;
                     ram_wr_data = row_data | (LANES'(1) << lowest_set(t));
                     count_in    = count_ff + CNT_BITS'(1);
                     idx_in      = base_ff + {{(32-SLOT_BITS){1'b0}}, f[SLOT_BITS-1:0]};
                     state_in    = S_DONE;
                  end else begin
                     row_in   = row_ff + ROW_BITS'(1);
                     state_in = S_RD;
                  end
               end
               OP_SET: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = row_data | lane_bit;
                  count_in    = count_ff + CNT_BITS'(1);
                  idx_in      = base_ff + {{(32-SLOT_BITS){1'b0}}, pick_ff};
                  state_in    = S_DONE;
               end
               OP_FREE: begin
                  if ((row_data & lane_bit) == '0) begin
                     status_in = ST_IS_FREE;
                     state_in  = S_DONE;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = row_data & ~lane_bit;
                     count_in    = count_ff - CNT_BITS'(1);
                     if (lo < MID) begin
                        op_in    = OP_SLO;
                        row_in   = lo1[SLOT_BITS-1:LANE_BITS];
                        state_in = S_RD;
                     end else begin
                        go_shi = 1'b1;
                     end
                  end
               end
               OP_SLO: begin
                  t = row_data & slo_m;
                  if (|t) begin
                     f      = rowbase + pos_type'(lowest_set(t));
                     nl     = (f <= MID) ? f - pos_type'(1) : MID;
                     go_shi = 1'b1;
                  end else if (rowend >= MID) begin
                     nl     = MID;
                     go_shi = 1'b1;
                  end else begin
                     row_in   = row_ff + ROW_BITS'(1);
                     state_in = S_RD;
                  end
                  if (go_shi) low_in = nl[CNT_BITS-1:0];
               end
               OP_SHI: begin
                  t = row_data & shi_m;
                  if (|t) begin
                     f        = rowbase + pos_type'(highest_set(t)) + pos_type'(1);
                     high_in  = f[CNT_BITS-1:0];
                     state_in = S_DONE;
                  end else if (rowbase <= lo1) begin
                     high_in  = lo1[CNT_BITS-1:0];
                     state_in = S_DONE;
                  end else begin
                     row_in   = row_ff - ROW_BITS'(1);
                     state_in = S_RD;
                  end
               end
               default: state_in = S_DONE;
            endcase
            if (go_shi) begin
               if (hi > nl + pos_type'(1)) begin
                  op_in    = OP_SHI;
                  row_in   = hm1[SLOT_BITS-1:LANE_BITS];
                  state_in = S_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         low_ff       <= CNT_BITS'(ENTRIES / 2);
         high_ff      <= CNT_BITS'(ENTRIES / 2 + 1);
         count_ff     <= '0;
         base_ff      <= '0;
         row_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
         count_ff <= count_in;
         if (csr_wr_en) base_ff <= csr_wr_data;
         if (ram_wr_en) row_valid_ff[row_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      row_ff    <= row_in;
      pick_ff   <= pick_in;
      status_ff <= status_in;
      idx_ff    <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tuser_ff <= status_ff;
         rsp_tdata_ff <= {5'b0, high_ff, low_ff, count_ff, idx_ff};
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

/* hdl/mosa_checker.sv */
module mosa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   import mosa_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp changed while stalled");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_FULL |-> rsp_tdata[31:0] == 32'd0)
      else $error("full result carries a slot index");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[40:32] <= 9'(ENTRIES))
      else $error("used count out of range");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

endmodule

bind middle_out_slot_allocator_unit mosa_checker u_mosa_checker (.*);
